FILE: hdl/rtpp_pkg.sv
package rtpp_pkg;

   localparam int NDIV = 34;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);

   localparam logic [2:0] REG_FOCAL  = 3'd0;
   localparam logic [2:0] REG_CENTER = 3'd1;
   localparam logic [2:0] REG_ROT0   = 3'd2;
   localparam logic [2:0] REG_ROT1   = 3'd3;
   localparam logic [2:0] REG_ROT2   = 3'd4;
   localparam logic [2:0] REG_TX     = 3'd5;
   localparam logic [2:0] REG_TY     = 3'd6;
   localparam logic [2:0] REG_TZ     = 3'd7;

   typedef struct packed {
      logic [47:0]       focal;
      logic [47:0]       center;
      logic [2:0][47:0]  rot;
      logic [2:0][31:0]  trans;
   } rtpp_cfg_type;

   typedef struct packed {
      logic [55:0] num_u;
      logic        neg_u;
      logic [55:0] num_v;
      logic        neg_v;
      logic [30:0] z;
      logic        inval;
   } rtpp_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rtpp_fifo_stat_type;

endpackage

FILE: hdl/rigid_transform_pinhole_projection_top.sv
// A point passes through 4 front stages, 1 queue slot, 35 divider stages and 1 output
// register. Throughput: one point per cycle unless the output or the full queue stalls,
// set by the one-bit-per-stage pipelined divider.
// A 4-entry queue between front and divider lets each side stall on its own.
// Reset (synchronous, active high) clears the configuration and all valid bits, which
// empties the pipeline and the queue; data registers keep their contents.
module rigid_transform_pinhole_projection_top import rtpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // point_x, point_y, point_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // pixel_u, pixel_v
   output logic [0:0]  rsp_tuser,  // depth_invalid
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   rtpp_cfg_type       cfg_ff;
   rtpp_entry_type     f_entry, q_entry;
   rtpp_fifo_stat_type q_stat;
   logic               f_valid, f_adv, b_adv, push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_FOCAL:  cfg_ff.focal    <= csr_wdata;
            REG_CENTER: cfg_ff.center   <= csr_wdata;
            REG_ROT0:   cfg_ff.rot[0]   <= csr_wdata;
            REG_ROT1:   cfg_ff.rot[1]   <= csr_wdata;
            REG_ROT2:   cfg_ff.rot[2]   <= csr_wdata;
            REG_TX:     cfg_ff.trans[0] <= csr_wdata[31:0];
            REG_TY:     cfg_ff.trans[1] <= csr_wdata[31:0];
            REG_TZ:     cfg_ff.trans[2] <= csr_wdata[31:0];
            default:    cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign f_adv      = !q_stat.full;
   assign req_tready = f_adv;
   assign push       = f_adv && f_valid;
   assign pop        = b_adv && !q_stat.empty;

   rtpp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .adv       (f_adv),
      .out_valid (f_valid),
      .out_entry (f_entry)
   );

   rtpp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (f_entry),
      .pop       (pop),
      .pop_data  (q_entry),
      .stat      (q_stat)
   );

   rtpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (!q_stat.empty),
      .in_entry  (q_entry),
      .adv       (b_adv),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_inval (rsp_tuser[0]),
      .out_ready (rsp_tready)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_inval_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 64'd0)
      else $error("invalid depth with nonzero pixels");

   a_queue_stat: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue full and empty at once");

endmodule

FILE: hdl/rtpp_front.sv
module rtpp_front import rtpp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  rtpp_cfg_type   cfg,
   input  logic           in_valid,
   input  logic [95:0]    in_data,
   input  logic           adv,
   output logic           out_valid,
   output rtpp_entry_type out_entry
);

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [47:0] prod_ff [9];
   logic signed [50:0] acc_ff [3];
   logic signed [31:0] cam_ff [3];
   rtpp_entry_type     ent_ff;

   logic signed [31:0] pt [3];
   logic signed [50:0] w [3];
   logic signed [50:0] r [3];
   logic signed [31:0] cam_in [3];
   logic [31:0]        mag_x, mag_y;

   always_comb begin
      pt[0] = signed'(in_data[31:0]);
      pt[1] = signed'(in_data[63:32]);
      pt[2] = signed'(in_data[95:64]);
      for (int i = 0; i < 3; i++) begin
         w[i] = acc_ff[i] + 51'sd8192;
         r[i] = w[i] >>> 14;
         if (r[i] > 51'sd2147483647) begin
            cam_in[i] = 32'sh7fffffff;
         end else if (r[i] < -51'sd2147483648) begin
            cam_in[i] = 32'sh80000000;
         end else begin
            cam_in[i] = r[i][31:0];
         end
      end
      mag_x = cam_ff[0][31] ? (~cam_ff[0] + 32'd1) : cam_ff[0];
      mag_y = cam_ff[1][31] ? (~cam_ff[1] + 32'd1) : cam_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i*3+j] <= signed'(cfg.rot[i][47-16*j -: 16]) * pt[j];
            end
            acc_ff[i] <= {{3{prod_ff[i*3][47]}}, prod_ff[i*3]}
                       + {{3{prod_ff[i*3+1][47]}}, prod_ff[i*3+1]}
                       + {{3{prod_ff[i*3+2][47]}}, prod_ff[i*3+2]}
                       + {{5{cfg.trans[i][31]}}, cfg.trans[i], 14'b0};
            cam_ff[i] <= cam_in[i];
         end
         ent_ff.num_u <= cfg.focal[47:24] * mag_x;
         ent_ff.num_v <= cfg.focal[23:0] * mag_y;
         ent_ff.neg_u <= cam_ff[0][31];
         ent_ff.neg_v <= cam_ff[1][31];
         ent_ff.z     <= cam_ff[2][30:0];
         ent_ff.inval <= cam_ff[2][31] || (cam_ff[2] == 32'sd0);
      end
   end

   assign out_valid = v4_ff;
   assign out_entry = ent_ff;

endmodule

FILE: hdl/rtpp_fifo.sv
module rtpp_fifo import rtpp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rtpp_entry_type     push_data,
   input  logic               pop,
   output rtpp_entry_type     pop_data,
   output rtpp_fifo_stat_type stat
);

   rtpp_entry_type       mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   assign pop_data   = mem[rd_ff];
   assign stat.full  = (cnt_ff == FIFO_DEPTH[FIFO_AW:0]);
   assign stat.empty = (cnt_ff == '0);

endmodule

FILE: hdl/rtpp_back.sv
module rtpp_back import rtpp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  rtpp_cfg_type   cfg,
   input  logic           in_valid,
   input  rtpp_entry_type in_entry,
   output logic           adv,
   output logic           out_valid,
   output logic [63:0]    out_data,
   output logic           out_inval,
   input  logic           out_ready
);

   logic        vld_ff [NDIV+1];
   logic        inv_ff [NDIV+1];
   logic [30:0] z_ff   [NDIV+1];
   logic        ovf_ff [2][NDIV+1];
   logic        neg_ff [2][NDIV+1];
   logic [30:0] rem_ff [2][NDIV+1];
   logic [33:0] nq_ff  [2][NDIV+1];

   logic        ov_ff;
   logic [63:0] od_ff;
   logic        oi_ff;

   logic [55:0] num [2];
   logic        neg [2];

   function automatic logic [64:0] div_step(input logic [30:0] rem, input logic [33:0] nq,
                                            input logic [30:0] z);
      logic [31:0] r2;
      logic        ge;
      logic [31:0] d;
      r2 = {rem, nq[33]};
      ge = r2 >= {1'b0, z};
      d  = r2 - {1'b0, z};
      return {ge ? d[30:0] : r2[30:0], nq[32:0], ge};
   endfunction

   function automatic logic [31:0] finish(input logic ovf, input logic [33:0] q0,
                                          input logic [30:0] rem, input logic [30:0] z,
                                          input logic neg, input logic [23:0] c);
      logic        up;
      logic [34:0] q;
      logic [36:0] sq;
      logic signed [36:0] s;
      up = {rem, 1'b0} >= {1'b0, z};
      q  = ovf ? 35'h400000000 : ({1'b0, q0} + {34'd0, up});
      sq = neg ? (~{2'b0, q} + 37'd1) : {2'b0, q};
      s  = signed'(sq + {5'b0, c, 8'b0});
      if (s > 37'sd2147483647) begin
         return 32'h7fffffff;
      end else if (s < -37'sd2147483648) begin
         return 32'h80000000;
      end
      return s[31:0];
   endfunction

   assign adv = !ov_ff || out_ready;

   always_comb begin
      num[0] = in_entry.num_u;
      num[1] = in_entry.num_v;
      neg[0] = in_entry.neg_u;
      neg[1] = in_entry.neg_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NDIV; s++) begin
            vld_ff[s] <= 1'b0;
         end
         ov_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s <= NDIV; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         ov_ff <= vld_ff[NDIV];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         inv_ff[0] <= in_entry.inval;
         z_ff[0]   <= in_entry.z;
         for (int l = 0; l < 2; l++) begin
            ovf_ff[l][0] <= {1'b0, num[l][55:26]} >= in_entry.z;
            neg_ff[l][0] <= neg[l];
            rem_ff[l][0] <= {1'b0, num[l][55:26]};
            nq_ff[l][0]  <= {num[l][25:0], 8'b0};
         end
         for (int s = 1; s <= NDIV; s++) begin
            inv_ff[s] <= inv_ff[s-1];
            z_ff[s]   <= z_ff[s-1];
            for (int l = 0; l < 2; l++) begin
               ovf_ff[l][s] <= ovf_ff[l][s-1];
               neg_ff[l][s] <= neg_ff[l][s-1];
               {rem_ff[l][s], nq_ff[l][s]} <= div_step(rem_ff[l][s-1], nq_ff[l][s-1],
                                                       z_ff[s-1]);
            end
         end
         oi_ff <= inv_ff[NDIV];
         if (inv_ff[NDIV]) begin
            od_ff <= '0;
         end else begin
            od_ff[31:0]  <= finish(ovf_ff[0][NDIV], nq_ff[0][NDIV], rem_ff[0][NDIV],
                                   z_ff[NDIV], neg_ff[0][NDIV], cfg.center[47:24]);
            od_ff[63:32] <= finish(ovf_ff[1][NDIV], nq_ff[1][NDIV], rem_ff[1][NDIV],
                                   z_ff[NDIV], neg_ff[1][NDIV], cfg.center[23:0]);
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   assign out_inval = oi_ff;

endmodule
